### src/wspm_pkg.sv
// Shared types and constants for the working set page monitor.
// No dependencies; imported by the RAM, the top level and the testbench.
package wspm_pkg;

  localparam int unsigned TAG_W    = 58;   // 64-bit address, smallest page is 64 bytes
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned SHIFT_MIN = 6;
  localparam int unsigned SHIFT_MAX = 30;

  localparam logic [1:0] MODE_INSN  = 2'd0;
  localparam logic [1:0] MODE_DATA  = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;

  localparam logic [1:0] REG_PAGE_SIZE_LOG2  = 2'd0;
  localparam logic [1:0] REG_SAMPLE_INTERVAL = 2'd1;
  localparam logic [1:0] REG_WINDOW_LENGTH   = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] access_address;
    logic [47:0] insn_count;
  } in_req_t;

  typedef struct packed {
    logic [47:0]        sample_time;
    logic [COUNT_W-1:0] insn_pages;
    logic [COUNT_W-1:0] data_pages;
    logic               overflowed;
  } out_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_CHECK,
    ST_WALK,
    ST_SEND
  } state_e;

endpackage

### src/working_set_page_monitor.sv
// Working set page monitor: request channel in, sample channel out, config writes.
// Each access kind has a hashed page table (linear probing) in a wspm_ram.
// Usage:
//   in_req_i carries mode, byte address and instruction count. Mode 0 is an
//   instruction fetch, 1 a data access, 2 a flush that forces a sample; mode 3
//   is dropped. A request is taken when in_valid_i and in_ready_o are high.
//   An access probes its hashed slot and, on a collision, each following slot
//   in turn, wrapping at the end of the table (at most PAGE_ENTRIES probes).
//   The probe loop through the table RAM sets the rate.
//   When an access reaches the next sample point, or on a flush, both tables
//   are walked in parallel, then in the send state the sample lands in the
//   output register once it is free. The sample register frees the input
//   side, so new requests are taken while a sample waits; a following sample
//   waits in place until out_ready_i takes the previous one.
//   After reset the tables are cleared, one entry per cycle, over all
//   PAGE_ENTRIES entries; in_ready_o stays low meanwhile. Config writes (cfg_valid_i,
//   cfg_index_i, cfg_data_i) are always taken and must occur only when idle.
module working_set_page_monitor
  import wspm_pkg::*;
#(
  parameter int unsigned PAGE_ENTRIES = 1024,
  parameter int unsigned TIME_BITS    = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_req_t     in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_rsp_t    out_rsp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i
);

  localparam int unsigned IDXW  = $clog2(PAGE_ENTRIES);
  localparam int unsigned CW    = $clog2(PAGE_ENTRIES + 1);
  localparam int unsigned TB    = TIME_BITS;
  localparam int unsigned DW    = 1 + TAG_W + TB;
  localparam int unsigned NCH   = (TAG_W + IDXW - 1) / IDXW;
  localparam logic [CW-1:0] N_C    = CW'(PAGE_ENTRIES);
  localparam logic [CW-1:0] LAST_C = CW'(PAGE_ENTRIES - 1);
  localparam logic [COUNT_W-1:0] CNT_MAX = '1;

  // fold the tag into a table index, then reduce below the table size
  function automatic logic [IDXW-1:0] hash_idx(input logic [TAG_W-1:0] tag);
    logic [TAG_W+IDXW-1:0] ext;
    logic [IDXW-1:0]       h;
    logic [IDXW:0]         r;
    ext = {{IDXW{1'b0}}, tag};
    h   = '0;
    for (int k = 0; k < NCH; k++) begin
      h = h ^ ext[k*IDXW +: IDXW];
    end
    r = {1'b0, h};
    if (r >= (IDXW+1)'(PAGE_ENTRIES)) begin
      r = r - (IDXW+1)'(PAGE_ENTRIES);
    end
    return r[IDXW-1:0];
  endfunction

  state_e state_q, state_d;

  logic [4:0]       psl_q, psl_d;
  logic [30:0]      intv_q, intv_d;
  logic [30:0]      win_q, win_d;

  logic [1:0]       mode_q, mode_d;
  logic [TAG_W-1:0] tag_q, tag_d;
  logic [TB-1:0]    now_q, now_d;
  logic [TB-1:0]    lower_q;
  logic [IDXW-1:0]  idx_q, idx_d;
  logic [CW-1:0]    probe_q, probe_d;
  logic             ovf_q, ovf_d;
  logic [TB-1:0]    next_q, next_d;
  logic [CW-1:0]    wc_q, wc_d;
  logic [CW-1:0]    clr_q, clr_d;
  logic [COUNT_W-1:0] cnt_i_q, cnt_i_d, cnt_d_q, cnt_d_d;
  logic             out_valid_q, out_valid_d;
  out_rsp_t         out_q, out_d;

  logic             in_acc;
  logic [4:0]       shift;
  logic [63:0]      addr_sh;
  logic [TAG_W-1:0] in_tag;
  logic [TB+47:0]   now_ext;
  logic [TB+47:0]   now_back;
  logic [TB:0]      next_sum;

  logic [IDXW-1:0]  raddr;
  logic [IDXW-1:0]  waddr;
  logic [DW-1:0]    wdata;
  logic             we_i_tab, we_d_tab;
  logic [DW-1:0]    q_i, q_d, q_sel;
  logic             e_valid;
  logic [TAG_W-1:0] e_tag;
  logic             probe_free, send_ok;
  logic [IDXW-1:0]  idx_next;

  wspm_ram #(.DEPTH(PAGE_ENTRIES), .AW(IDXW), .DW(DW)) u_insn_ram (
    .clk_i   (clk_i),
    .we_i    (we_i_tab),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (q_i)
  );

  wspm_ram #(.DEPTH(PAGE_ENTRIES), .AW(IDXW), .DW(DW)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (we_d_tab),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (q_d)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // clamp page shift and form the tag
  always_comb begin
    shift = psl_q;
    if (psl_q < 5'(SHIFT_MIN)) shift = 5'(SHIFT_MIN);
    if (psl_q > 5'(SHIFT_MAX)) shift = 5'(SHIFT_MAX);
  end
  assign addr_sh = in_req_i.access_address >> shift;
  assign in_tag  = addr_sh[TAG_W-1:0];
  assign now_ext = {{TB{1'b0}}, in_req_i.insn_count};
  assign now_back = {48'b0, now_q};
  assign next_sum = {1'b0, now_q} + (TB+1)'(intv_q);

  assign q_sel      = (mode_q == MODE_INSN) ? q_i : q_d;
  assign e_valid    = q_sel[DW-1];
  assign e_tag      = q_sel[DW-2 -: TAG_W];
  assign probe_free = !e_valid || (e_tag == tag_q);
  assign send_ok    = !out_valid_q || out_ready_i;
  assign idx_next   = ({1'b0, idx_q} == (IDXW+1)'(PAGE_ENTRIES - 1)) ? '0 : idx_q + 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == LAST_C) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req_i.mode == MODE_FLUSH) state_d = ST_WALK;
          else if (in_req_i.mode == MODE_INSN || in_req_i.mode == MODE_DATA)
            state_d = ST_PROBE;
        end
      end
      ST_PROBE: if (probe_free || probe_q == LAST_C) state_d = ST_CHECK;
      ST_CHECK: state_d = (now_q >= next_q) ? ST_WALK : ST_IDLE;
      ST_WALK:  if (wc_q == N_C) state_d = ST_SEND;
      ST_SEND:  if (send_ok) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    psl_d    = psl_q;
    intv_d   = intv_q;
    win_d    = win_q;
    mode_d   = mode_q;
    tag_d    = tag_q;
    now_d    = now_q;
    idx_d    = idx_q;
    probe_d  = probe_q;
    ovf_d    = ovf_q;
    next_d   = next_q;
    wc_d     = wc_q;
    clr_d    = clr_q;
    cnt_i_d  = cnt_i_q;
    cnt_d_d  = cnt_d_q;
    out_d    = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    raddr    = idx_q;
    waddr    = idx_q;
    wdata    = {1'b1, tag_q, now_q};
    we_i_tab = 1'b0;
    we_d_tab = 1'b0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PAGE_SIZE_LOG2:  psl_d  = cfg_data_i[4:0];
        REG_SAMPLE_INTERVAL: intv_d = cfg_data_i;
        REG_WINDOW_LENGTH:   win_d  = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_CLEAR: begin
        waddr    = clr_q[IDXW-1:0];
        wdata    = '0;
        we_i_tab = 1'b1;
        we_d_tab = 1'b1;
        clr_d    = clr_q + 1'b1;
      end
      ST_IDLE: begin
        raddr = hash_idx(in_tag);
        if (in_acc) begin
          mode_d  = in_req_i.mode;
          tag_d   = in_tag;
          now_d   = now_ext[TB-1:0];
          idx_d   = hash_idx(in_tag);
          probe_d = '0;
          wc_d    = '0;
          cnt_i_d = '0;
          cnt_d_d = '0;
        end
      end
      ST_PROBE: begin
        if (probe_free) begin
          we_i_tab = (mode_q == MODE_INSN);
          we_d_tab = (mode_q != MODE_INSN);
        end else if (probe_q == LAST_C) begin
          ovf_d = 1'b1;  // every slot holds another page
        end else begin
          idx_d   = idx_next;
          raddr   = idx_next;
          probe_d = probe_q + 1'b1;
        end
      end
      ST_CHECK: begin
        wc_d    = '0;
        cnt_i_d = '0;
        cnt_d_d = '0;
        if (now_q >= next_q) begin
          next_d = next_sum[TB] ? '1 : next_sum[TB-1:0];
        end
      end
      ST_WALK: begin
        raddr = wc_q[IDXW-1:0];
        wc_d  = wc_q + 1'b1;
        // entry read in the previous cycle is on the RAM outputs now
        if (wc_q != '0) begin
          if (q_i[DW-1] && q_i[TB-1:0] > lower_q && cnt_i_q != CNT_MAX)
            cnt_i_d = cnt_i_q + 1'b1;
          if (q_d[DW-1] && q_d[TB-1:0] > lower_q && cnt_d_q != CNT_MAX)
            cnt_d_d = cnt_d_q + 1'b1;
        end
      end
      ST_SEND: begin
        if (send_ok) begin
          out_d.sample_time = now_back[47:0];
          out_d.insn_pages  = cnt_i_q;
          out_d.data_pages  = cnt_d_q;
          out_d.overflowed  = ovf_q;
          out_valid_d       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      psl_q       <= 5'd12;
      intv_q      <= 31'd100000;
      win_q       <= 31'd100000;
      ovf_q       <= 1'b0;
      next_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      probe_q     <= '0;
      wc_q        <= '0;
    end else begin
      state_q     <= state_d;
      psl_q       <= psl_d;
      intv_q      <= intv_d;
      win_q       <= win_d;
      ovf_q       <= ovf_d;
      next_q      <= next_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      probe_q     <= probe_d;
      wc_q        <= wc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    tag_q   <= tag_d;
    now_q   <= now_d;
    idx_q   <= idx_d;
    cnt_i_q <= cnt_i_d;
    cnt_d_q <= cnt_d_d;
    out_q   <= out_d;
    // window lower bound, zero when the window reaches back past time zero
    lower_q <= (TB'(win_q) < now_q) ? now_q - TB'(win_q) : '0;
  end

endmodule

### src/wspm_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Uses wspm_pkg only by convention; holds one page table.
module wspm_ram
  import wspm_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 107
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### tb/testbench.sv
// Self-checking testbench for working_set_page_monitor: random and directed
// accesses and flushes, with a built-in page table predictor. Depends on wspm_pkg.
`timescale 1ns / 100ps

module testbench;
  import wspm_pkg::*;

  localparam int unsigned ENTRIES = 1024;
  localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
  localparam int unsigned DRAIN_CYCLES = 2 * ENTRIES + 100;
  localparam longint unsigned CYCLE_LIMIT = 64'd20_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_req_t     in_req_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_rsp_t    out_rsp_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = REG_PAGE_SIZE_LOG2;
  logic [30:0] cfg_data_i = '0;

  working_set_page_monitor DUT (.*);

  always #5 clk_i = ~clk_i;

  // shadow of the block's state
  logic [4:0]  sh_page_log2 = 5'd12;
  logic [30:0] sh_interval  = 31'd100000;
  logic [30:0] sh_window    = 31'd100000;
  logic [57:0] pg_tag   [2][ENTRIES];
  bit          pg_valid [2][ENTRIES];
  logic [47:0] pg_stamp [2][ENTRIES];
  logic [47:0] next_sample = '0;
  bit          overflow_seen = 1'b0;

  in_req_t  pending_reqs[$];
  out_rsp_t sample_q[$];
  int unsigned mismatches = 0, samples_checked = 0, accesses_taken = 0, cfg_writes = 0;
  longint unsigned cycles = 0;

  logic [63:0] insn_pool[200];
  logic [63:0] data_pool[200];
  logic [47:0] tnow;

  function automatic logic [10:0] recent_pages(int k, logic [47:0] now);
    logic [47:0] lower;
    logic [10:0] cnt;
    lower = ({17'b0, sh_window} < now) ? now - {17'b0, sh_window} : '0;
    cnt = '0;
    for (int i = 0; i < ENTRIES; i++)
      if (pg_valid[k][i] && pg_stamp[k][i] > lower && cnt != 11'h7FF) cnt++;
    return cnt;
  endfunction

  function automatic void push_sample(logic [47:0] now);
    out_rsp_t s;
    s.sample_time = now;
    s.insn_pages  = recent_pages(0, now);
    s.data_pages  = recent_pages(1, now);
    s.overflowed  = overflow_seen;
    sample_q.push_back(s);
  endfunction

  function automatic void track_access(in_req_t r);
    int k, shift, free_slot;
    logic [57:0] tag;
    bit hit;
    if (r.mode == MODE_FLUSH) begin
      push_sample(r.insn_count);
      return;
    end
    if (r.mode != MODE_INSN && r.mode != MODE_DATA) return;
    k = (r.mode == MODE_INSN) ? 0 : 1;
    shift = sh_page_log2;
    if (shift < SHIFT_MIN) shift = SHIFT_MIN;
    if (shift > SHIFT_MAX) shift = SHIFT_MAX;
    tag = 58'(r.access_address >> shift);
    free_slot = -1;
    hit = 1'b0;
    for (int i = 0; i < ENTRIES && !hit; i++) begin
      if (pg_valid[k][i]) begin
        if (pg_tag[k][i] == tag) begin
          pg_stamp[k][i] = r.insn_count;
          hit = 1'b1;
        end
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (!hit) begin
      if (free_slot < 0) overflow_seen = 1'b1;
      else begin
        pg_tag[k][free_slot] = tag;
        pg_stamp[k][free_slot] = r.insn_count;
        pg_valid[k][free_slot] = 1'b1;
      end
    end
    if (r.insn_count < next_sample) return;
    push_sample(r.insn_count);
    if ({17'b0, sh_interval} > TMAX - r.insn_count) next_sample = TMAX;
    else next_sample = r.insn_count + {17'b0, sh_interval};
  endfunction

  // request driver: bursts with random gaps
  int unsigned burst_left = 1, gap_left = 0;
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      track_access(in_req_i);
      accesses_taken++;
    end
    if (in_valid_i && !in_ready_o) begin
      // hold the request
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid_i <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      in_req_i   <= pending_reqs.pop_front();
      in_valid_i <= 1'b1;
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // sample monitor and receiver stall pattern
  int unsigned stall_mode = 0;
  always @(posedge clk_i) begin
    out_rsp_t exp_s;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[working_set_page_monitor] ERROR");
      $finish;
    end
    if (out_valid_o && out_ready_i) begin
      if (sample_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample %p", out_rsp_o);
      end else begin
        exp_s = sample_q.pop_front();
        samples_checked++;
        if (exp_s.sample_time !== out_rsp_o.sample_time || exp_s.insn_pages !== out_rsp_o.insn_pages
            || exp_s.data_pages !== out_rsp_o.data_pages
            || exp_s.overflowed !== out_rsp_o.overflowed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample mismatch: expected %p, got %p", exp_s, out_rsp_o);
        end
      end
    end
    if (cycles % 200 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 9) < 6);
      default: out_ready_i <= (cycles % 11 > 3);
    endcase
  end

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_PAGE_SIZE_LOG2:  sh_page_log2 = val[4:0];
      REG_SAMPLE_INTERVAL: sh_interval = val;
      REG_WINDOW_LENGTH:   sh_window = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic queue_req(logic [1:0] mode, logic [63:0] addr, logic [47:0] t);
    in_req_t r;
    r.mode = mode;
    r.access_address = addr;
    r.insn_count = t;
    pending_reqs.push_back(r);
  endtask

  // block is idle: nothing queued, nothing expected, walk/probe finished
  task automatic wait_idle();
    forever begin
      wait (pending_reqs.size() == 0 && !in_valid_i && sample_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      if (pending_reqs.size() == 0 && sample_q.size() == 0) break;
    end
  endtask

  task automatic queue_random(int n);
    int unsigned pick;
    logic [63:0] addr;
    logic [1:0] mode;
    repeat (n) begin
      tnow += $urandom_range(0, 400);
      if ($urandom_range(0, 99) < 4 && tnow[39:0] > 40'd3000) tnow -= $urandom_range(0, 2000);
      pick = $urandom_range(0, 99);
      if (pick < 5) mode = MODE_FLUSH;
      else if (pick < 7) mode = 2'd3;  // unused code, ignored
      else mode = (pick < 52) ? MODE_INSN : MODE_DATA;
      if ($urandom_range(0, 9) == 0) addr = {$urandom, $urandom};
      else if (mode == MODE_INSN) addr = insn_pool[$urandom_range(0, 199)] ^ $urandom_range(0, 63);
      else addr = data_pool[$urandom_range(0, 199)] ^ $urandom_range(0, 63);
      queue_req(mode, addr, tnow);
    end
  endtask

  initial begin
    foreach (insn_pool[i]) insn_pool[i] = {$urandom, $urandom};
    foreach (data_pool[i]) data_pool[i] = {$urandom, $urandom};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults: time zero edge cases, ignored code, first interval
    queue_req(MODE_FLUSH, '0, '0);
    queue_req(MODE_INSN, '0, '0);
    queue_req(MODE_DATA, '1, 48'd5);
    queue_req(2'd3, '1, 48'd7);
    queue_req(MODE_INSN, 64'h8000_0000_0000_0040, 48'd99999);
    queue_req(MODE_DATA, 64'h1000, 48'd100000);
    queue_req(MODE_FLUSH, '1, 48'd100001);
    wait_idle();

    // zero interval and zero window, page size below range
    write_reg(REG_PAGE_SIZE_LOG2, 31'd0);
    write_reg(REG_SAMPLE_INTERVAL, 31'd0);
    write_reg(REG_WINDOW_LENGTH, 31'd0);
    queue_req(MODE_INSN, 64'h40, 48'd200050);
    queue_req(MODE_INSN, 64'h80, 48'd200040);
    queue_req(MODE_DATA, 64'h7F, 48'd200030);
    queue_req(MODE_DATA, 64'hC0, 48'd200060);
    queue_req(MODE_FLUSH, '0, 48'd200035);
    wait_idle();

    // page size above range, widest interval and window
    write_reg(REG_PAGE_SIZE_LOG2, 31'd31);
    write_reg(REG_SAMPLE_INTERVAL, 31'h7FFF_FFFF);
    write_reg(REG_WINDOW_LENGTH, 31'h7FFF_FFFF);
    queue_req(MODE_INSN, 64'h3FFF_FFFF, 48'd300000);
    queue_req(MODE_INSN, 64'h4000_0000, 48'd300001);
    queue_req(MODE_DATA, 64'hFFFF_FFFF_FFFF_FFFF, 48'd300002);
    queue_req(MODE_FLUSH, '0, 48'd300003);
    wait_idle();

    for (int ph = 1; ph <= 5; ph++) begin
      write_reg(REG_PAGE_SIZE_LOG2, 31'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                                     : $urandom_range(6, 16)));
      write_reg(REG_SAMPLE_INTERVAL, 31'($urandom_range(500, 20000)));
      write_reg(REG_WINDOW_LENGTH, 31'(($urandom_range(0, 4) == 0) ? {$urandom} >> 1
                                                                  : $urandom_range(1, 8000)));
      tnow = {ph[3:0], 4'b0, 40'($urandom)} + 48'h1000_0000;
      queue_random(130);
      wait_idle();
    end

    // fill the instruction table past capacity
    write_reg(REG_PAGE_SIZE_LOG2, 31'd6);
    write_reg(REG_SAMPLE_INTERVAL, 31'h7FFF_FFFF);
    tnow = 48'hF000_0000_0000;
    for (int i = 0; i < ENTRIES + 8; i++) queue_req(MODE_INSN, 64'(i) << 6, tnow + 48'(i));
    queue_req(MODE_FLUSH, '0, tnow + 48'd2000);
    wait_idle();

    // time at the top of its range: next sample point saturates
    queue_req(MODE_INSN, 64'h40, TMAX);
    queue_req(MODE_DATA, 64'h80, TMAX);
    queue_req(MODE_FLUSH, '0, TMAX);
    wait_idle();

    $display("accesses taken: %0d, samples checked: %0d, config writes: %0d",
             accesses_taken, samples_checked, cfg_writes);
    $display("mismatches: %0d, samples never seen: %0d", mismatches, sample_q.size());
    if (mismatches == 0 && sample_q.size() == 0) $display("[working_set_page_monitor] OK");
    else $display("[working_set_page_monitor] ERROR");
    $finish;
  end

endmodule

### filelist.f
src/wspm_pkg.sv
src/wspm_ram.sv
src/working_set_page_monitor.sv
tb/testbench.sv
